// ----- rtl/srm_pkg.sv -----
package srm_pkg;

    localparam int VALUE_W = 32;
    localparam int TIME_W  = 32;
    localparam int PCT_W   = 31;

    // Tolerance rules, all in Q16.16 LSBs
    localparam logic [VALUE_W-1:0] TINY_STEP_LSB = VALUE_W'(66);
    localparam logic [VALUE_W-1:0] FLAT_TOL_LSB  = VALUE_W'(3277);
    localparam logic [VALUE_W-1:0] MIN_TOL_LSB   = VALUE_W'(7);

    // floor(x / 25) = (x * RECIP25) >> 36 and floor(x / 5) = (x * RECIP5) >> 33, x < 2^31
    localparam int                 RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP25     = 32'd2748779070;
    localparam int                 RECIP25_SH  = 36;
    localparam logic [RECIP_W-1:0] RECIP5      = 32'd1717986919;
    localparam int                 RECIP5_SH   = 33;
    localparam int                 PROD_W      = (VALUE_W - 1) + RECIP_W;

    // Overshoot: num * 100 * 65536 / range, saturating
    localparam int                 SCALE_W   = 23;
    localparam logic [SCALE_W-1:0] PCT_SCALE = 23'd6553600;
    localparam int                 DIVD_W    = VALUE_W + SCALE_W;
    localparam int                 RATIO_W   = 9;
    localparam logic [RATIO_W-1:0] SAT_RATIO = 9'd328;
    localparam logic [PCT_W-1:0]   PCT_MAX   = {PCT_W{1'b1}};

    localparam int DIV_STEPS = VALUE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [0:0] {
        REG_INITIAL = 1'b0,
        REG_TARGET  = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SCALE,
        S_BAND,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic calc;
        logic scale;
        logic band;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

// ----- rtl/srm_dp.sv -----
module srm_dp
    import srm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  t_reg_idx           i_cfg_index,
    input  logic [VALUE_W-1:0] i_cfg_data,
    input  logic [VALUE_W-1:0] i_sample_value,
    input  logic [TIME_W-1:0]  i_sample_time,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic [VALUE_W-1:0] o_extreme_val,
    output logic [TIME_W-1:0]  o_extreme_tick,
    output logic               o_is_settled,
    output logic [TIME_W-1:0]  o_settling_time,
    output logic [PCT_W-1:0]   o_overshoot_pct
);

    function automatic logic [VALUE_W-1:0] mag_of(input logic [VALUE_W:0] d);
        logic [VALUE_W:0] m;
        m = d[VALUE_W] ? (~d + 1'b1) : d;
        return m[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W:0] sdiff(input logic [VALUE_W-1:0] a,
                                               input logic [VALUE_W-1:0] b);
        return {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
    endfunction

    // set-up and tracking state
    logic signed [VALUE_W-1:0] r_init, r_tgt, r_peak;
    logic [TIME_W-1:0]         r_extreme_tick, r_entry;
    logic                      r_in_band;
    logic [CNT_W-1:0]          r_cnt;

    // working registers
    logic [VALUE_W-1:0] r_smp, r_range, r_dev, r_abs_tgt, r_tol_raw, r_num, r_rem, r_quo;
    logic [TIME_W-1:0]  r_now;
    logic               r_sat, r_zero;

    logic               rising, falling;
    logic [VALUE_W:0]   num_diff;
    logic [VALUE_W-1:0] num_c, tol_c, div_arg;
    logic [RECIP_W-1:0] div_recip;
    logic [PROD_W-1:0]  tol_prod;
    logic               tiny;
    logic [DIVD_W-1:0]  dividend;
    logic [VALUE_W+RATIO_W-1:0] sat_lim;
    logic [VALUE_W:0]   trial;
    logic               trial_ge;

    assign rising  = r_tgt > r_init;
    assign falling = r_tgt < r_init;

    always_comb begin
        num_diff = rising ? sdiff(r_peak, r_tgt) : sdiff(r_tgt, r_peak);
        if ((rising || falling) && !num_diff[VALUE_W] && num_diff != '0) begin
            num_c = num_diff[VALUE_W-1:0];
        end else begin
            num_c = '0;
        end
    end

    // one multiplier serves both constant divisions of the tolerance
    assign tiny      = r_range < TINY_STEP_LSB;
    assign div_arg   = tiny ? (r_abs_tgt >> 1) : (r_range >> 1);
    assign div_recip = tiny ? RECIP5 : RECIP25;
    assign tol_prod  = PROD_W'(div_arg[VALUE_W-2:0]) * PROD_W'(div_recip);

    assign tol_c    = (r_tol_raw < MIN_TOL_LSB) ? MIN_TOL_LSB : r_tol_raw;
    assign dividend = DIVD_W'(r_num) * DIVD_W'(PCT_SCALE);
    assign sat_lim  = (VALUE_W+RATIO_W)'(r_range) * (VALUE_W+RATIO_W)'(SAT_RATIO);

    assign trial    = {r_rem, r_quo[VALUE_W-1]};
    assign trial_ge = trial >= {1'b0, r_range};

    assign o_sts.div_done = r_cnt == CNT_W'(DIV_STEPS - 1);

    // control state: set-up registers, tracking state, step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init         <= '0;
            r_tgt          <= '0;
            r_peak         <= '0;
            r_extreme_tick <= '0;
            r_in_band      <= 1'b0;
            r_entry        <= '0;
            r_cnt          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INITIAL: begin
                    r_init <= i_cfg_data;
                    r_peak <= i_cfg_data;
                end
                REG_TARGET: begin
                    r_tgt  <= i_cfg_data;
                    r_peak <= r_init;
                end
                default: ;
            endcase
            r_extreme_tick <= '0;
            r_in_band      <= 1'b0;
            r_entry        <= '0;
        end else begin
            if (i_cmd.calc) begin
                if (rising && $signed(r_smp) > r_peak) begin
                    r_peak         <= r_smp;
                    r_extreme_tick <= r_now;
                end else if (falling && $signed(r_smp) < r_peak) begin
                    r_peak         <= r_smp;
                    r_extreme_tick <= r_now;
                end else if (!rising && !falling) begin
                    r_peak <= r_init;
                end
            end
            if (i_cmd.band) begin
                r_cnt <= '0;
                if (r_dev <= tol_c) begin
                    if (!r_in_band) begin
                        r_in_band <= 1'b1;
                        r_entry   <= r_now;
                    end
                end else begin
                    r_in_band <= 1'b0;
                    r_entry   <= '0;
                end
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_smp <= i_sample_value;
            r_now <= i_sample_time;
        end
        if (i_cmd.calc) begin
            r_range   <= mag_of(sdiff(r_tgt, r_init));
            r_dev     <= mag_of(sdiff(r_smp, r_tgt));
            r_abs_tgt <= mag_of({r_tgt[VALUE_W-1], r_tgt});
        end
        if (i_cmd.scale) begin
            r_num <= num_c;
            if (tiny) begin
                r_tol_raw <= (r_abs_tgt != '0) ?
                             VALUE_W'(tol_prod[PROD_W-1:RECIP5_SH]) : FLAT_TOL_LSB;
            end else begin
                r_tol_raw <= VALUE_W'(tol_prod[PROD_W-1:RECIP25_SH]);
            end
        end
        if (i_cmd.band) begin
            r_rem  <= VALUE_W'(dividend[DIVD_W-1:VALUE_W]);
            r_quo  <= dividend[VALUE_W-1:0];
            r_sat  <= (VALUE_W+RATIO_W)'(r_num) >= sat_lim;
            r_zero <= r_num == '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= trial_ge ? VALUE_W'(trial - {1'b0, r_range}) : trial[VALUE_W-1:0];
            r_quo <= {r_quo[VALUE_W-2:0], trial_ge};
        end
        if (i_cmd.load_out) begin
            o_extreme_val   <= r_peak;
            o_extreme_tick  <= r_extreme_tick;
            o_is_settled    <= r_in_band;
            o_settling_time <= r_in_band ? r_entry : '0;
            if (r_zero) begin
                o_overshoot_pct <= '0;
            end else if (r_sat || r_quo[VALUE_W-1]) begin
                o_overshoot_pct <= PCT_MAX;
            end else begin
                o_overshoot_pct <= r_quo[PCT_W-1:0];
            end
        end
    end

endmodule

// ----- rtl/srm_ctrl.sv -----
module srm_ctrl
    import srm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CALC;
            S_CALC:  n_state = S_SCALE;
            S_SCALE: n_state = S_BAND;
            S_BAND:  n_state = S_DIV;
            S_DIV:   if (i_sts.div_done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_CALC:  o_cmd.calc     = 1'b1;
            S_SCALE: o_cmd.scale    = 1'b1;
            S_BAND:  o_cmd.band     = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_DONE:  o_cmd.load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CALC))
        else $error("accepted sample did not start processing");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_out_valid && r_state == S_IDLE))
        else $error("loaded result not presented");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_done) |=> (r_state == S_DIV))
        else $error("divider left early");
`endif

endmodule

// ----- rtl/step_response_metrics_core.sv -----
// Channel      Dir  Handshake                     Payload
// s_axis       in   s_axis_tvalid/s_axis_tready   sample_value, sample_time
// m_axis       out  m_axis_tvalid/m_axis_tready   peak, peak time, settled, settling time,
//                                                 overshoot
// cfg          in   i_cfg_we (always taken)       i_cfg_index, i_cfg_data
//
// After its transfer, each sample passes through the calc, scale and band states of peak,
// magnitude, tolerance and band arithmetic, the radix-2 overshoot divider and a final
// state that loads the result register; the next transfer is taken only in the idle
// state, so a new sample is not taken until the block is through with the last one.
// Reset is synchronous and active low; it clears both set-up registers and the tracking
// state. The result register holds a finished result while the sink stalls; the next
// sample is taken meanwhile, and its result waits in the final state until the register
// frees.
module step_response_metrics_core
    import srm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration writes
    input  logic                     i_cfg_we,
    input  t_reg_idx                 i_cfg_index,
    input  logic [VALUE_W-1:0]       i_cfg_data,
    // samples in
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [VALUE_W+TIME_W-1:0] s_axis_tdata,  // sample_value, sample_time
    // results out
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // extreme_val, extreme_tick, is_settled, settling_time, overshoot_pct
    output logic [VALUE_W+2*TIME_W+PCT_W:0] m_axis_tdata
);

    t_cmd               cmd;
    t_sts               sts;
    logic [VALUE_W-1:0] extreme_val;
    logic [TIME_W-1:0]  extreme_tick, settling_time;
    logic               is_settled;
    logic [PCT_W-1:0]   overshoot_pct;

    // sequencing of each sample and the result register handshake
    srm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // peak tracking, settling band, overshoot divider, result register
    srm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample_value  (s_axis_tdata[VALUE_W-1:0]),
        .i_sample_time   (s_axis_tdata[VALUE_W+TIME_W-1:VALUE_W]),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_extreme_val   (extreme_val),
        .o_extreme_tick  (extreme_tick),
        .o_is_settled    (is_settled),
        .o_settling_time (settling_time),
        .o_overshoot_pct (overshoot_pct)
    );

    // pack the result fields from the lowest bit up
    assign m_axis_tdata = {overshoot_pct, settling_time, is_settled, extreme_tick, extreme_val};

endmodule
